FILE: rtl/srfd_pkg.sv
// shared types and constants for the source-route forward decider
// no dependencies; used by srfd_parser, srfd_decide and the top level
package srfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 25;
    localparam int MAX_HOPS_DEF    = 10;

    localparam int          HEADER_BYTES = 8;
    localparam logic [7:0]  FRAME_TYPE   = 8'h11;
    localparam int          ADDR_W       = 16;
    localparam int          BYTE_W       = 8;
    localparam int          LEN_W        = 10;
    localparam int          CFG_IDX_W    = 1;
    localparam int          VERDICT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLED = 1'd1;

    localparam logic [2:0] HDR_TYPE      = 3'd0;
    localparam logic [2:0] HDR_DEST_HI   = 3'd1;
    localparam logic [2:0] HDR_DEST_LO   = 3'd2;
    localparam logic [2:0] HDR_SRC_HI    = 3'd3;
    localparam logic [2:0] HDR_SRC_LO    = 3'd4;
    localparam logic [2:0] HDR_ID        = 3'd5;
    localparam logic [2:0] HDR_PAY_LEN   = 3'd6;
    localparam logic [2:0] HDR_ROUTE_LEN = 3'd7;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_TOO_SHORT  = 3'd0,
        VERDICT_WRONG_TYPE = 3'd1,
        VERDICT_LEN_ERROR  = 3'd2,
        VERDICT_DELIVER    = 3'd3,
        VERDICT_FORWARD    = 3'd4,
        VERDICT_NO_ROUTE   = 3'd5
    } verdict_t;

    // frame summary after the current byte, handed from parser to decision logic
    typedef struct packed {
        logic                is_short;
        logic                type_ok;
        logic                len_ok;
        logic                dest_here;
        logic                match_seen;
        logic                match_last;
        logic                route_nonempty;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   source;
        logic [BYTE_W-1:0]   id;
        logic [BYTE_W-1:0]   pay_len;
        logic [ADDR_W-1:0]   first_hop;
        logic [ADDR_W-1:0]   hop_after_match;
    } frame_sum_t;

    typedef struct packed {
        verdict_t            verdict;
        logic [ADDR_W-1:0]   next_hop;
        logic [ADDR_W-1:0]   first_hop;
    } decision_t;

endpackage

FILE: rtl/srfd_parser.sv
// byte-wise frame parser: header fields, length tracking and route hop scan
// depends on srfd_pkg
module srfd_parser #(
    parameter int MAX_PAYLOAD = srfd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_HOPS    = srfd_pkg::MAX_HOPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [srfd_pkg::BYTE_W-1:0]  byte_in,
    input  logic                         last_in,
    input  logic [srfd_pkg::ADDR_W-1:0]  node_address,
    output srfd_pkg::frame_sum_t         summary
);

    localparam int MAX_FRAME = srfd_pkg::HEADER_BYTES + MAX_PAYLOAD + 2 * MAX_HOPS;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int HOP_W     = $clog2(MAX_HOPS + 1);
    localparam int LW        = srfd_pkg::LEN_W;
    localparam int AW        = srfd_pkg::ADDR_W;
    localparam int BW        = srfd_pkg::BYTE_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             too_long_reg, too_long_next;
    logic [BW-1:0]    type_reg, type_next;
    logic [AW-1:0]    dest_reg, dest_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [BW-1:0]    id_reg, id_next;
    logic [BW-1:0]    plen_reg, plen_next;
    logic [BW-1:0]    rlen_reg, rlen_next;
    logic [BW-1:0]    hop_hi_reg, hop_hi_next;
    logic             match_reg, match_next;
    logic [HOP_W-1:0] midx_reg, midx_next;
    logic [AW-1:0]    after_reg, after_next;
    logic [AW-1:0]    first_reg, first_next;

    logic [LW-1:0]    q_off;
    logic [LW-1:0]    r_off;
    logic [LW-1:0]    hop_idx;
    logic [AW-1:0]    hop_word;
    logic [LW-1:0]    len_sum;

    always_comb
    begin
        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        type_next     = type_reg;
        dest_next     = dest_reg;
        src_next      = src_reg;
        id_next       = id_reg;
        plen_next     = plen_reg;
        rlen_next     = rlen_reg;
        hop_hi_next   = hop_hi_reg;
        match_next    = match_reg;
        midx_next     = midx_reg;
        after_next    = after_reg;
        first_next    = first_reg;

        q_off    = LW'(pos_reg) - LW'(srfd_pkg::HEADER_BYTES);
        r_off    = q_off - LW'(plen_reg);
        hop_idx  = r_off >> 1;
        hop_word = {hop_hi_reg, byte_in};

        if (!too_long_reg)
        begin
            if (pos_reg >= POS_W'(MAX_FRAME))
            begin
                too_long_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_W'(srfd_pkg::HEADER_BYTES))
                begin
                    case (pos_reg[2:0])
                        srfd_pkg::HDR_TYPE:      type_next = byte_in;
                        srfd_pkg::HDR_DEST_HI:   dest_next = {byte_in, dest_reg[BW-1:0]};
                        srfd_pkg::HDR_DEST_LO:   dest_next = {dest_reg[AW-1:BW], byte_in};
                        srfd_pkg::HDR_SRC_HI:    src_next  = {byte_in, src_reg[BW-1:0]};
                        srfd_pkg::HDR_SRC_LO:    src_next  = {src_reg[AW-1:BW], byte_in};
                        srfd_pkg::HDR_ID:        id_next   = byte_in;
                        srfd_pkg::HDR_PAY_LEN:   plen_next = byte_in;
                        srfd_pkg::HDR_ROUTE_LEN: rlen_next = byte_in;
                        default:                 type_next = type_reg;
                    endcase
                end
                else if (q_off >= LW'(plen_reg))
                begin
                    if (!r_off[0])
                    begin
                        hop_hi_next = byte_in;
                    end
                    else if (hop_idx < LW'(rlen_reg) && hop_idx < LW'(MAX_HOPS))
                    begin
                        if (hop_idx == '0)
                            first_next = hop_word;
                        if (match_reg && (LW'(midx_reg) + LW'(1) == hop_idx))
                            after_next = hop_word;
                        if (hop_word == node_address)
                        begin
                            match_next = 1'b1;
                            midx_next  = hop_idx[HOP_W-1:0];
                        end
                    end
                end
            end
        end
    end

    assign len_sum = LW'(srfd_pkg::HEADER_BYTES) + LW'(plen_next) + (LW'(rlen_next) << 1);

    always_comb
    begin
        summary.is_short       = !too_long_next
                                 && (pos_next < POS_W'(srfd_pkg::HEADER_BYTES));
        summary.type_ok        = (type_next == srfd_pkg::FRAME_TYPE);
        summary.len_ok         = !too_long_next
                                 && (plen_next <= BW'(MAX_PAYLOAD))
                                 && (rlen_next <= BW'(MAX_HOPS))
                                 && (len_sum == LW'(pos_next));
        summary.dest_here      = (dest_next == node_address);
        summary.match_seen     = match_next;
        summary.match_last     = (LW'(midx_next) + LW'(1) == LW'(rlen_next));
        summary.route_nonempty = (rlen_next != '0);
        summary.dest           = dest_next;
        summary.source         = src_next;
        summary.id             = id_next;
        summary.pay_len        = plen_next;
        summary.first_hop      = first_next;
        summary.hop_after_match = after_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
            type_reg     <= '0;
            dest_reg     <= '0;
            src_reg      <= '0;
            id_reg       <= '0;
            plen_reg     <= '0;
            rlen_reg     <= '0;
            hop_hi_reg   <= '0;
            match_reg    <= 1'b0;
            midx_reg     <= '0;
            after_reg    <= '0;
            first_reg    <= '0;
        end
        else if (advance)
        begin
            if (last_in)
            begin
                // frame done, start clean
                pos_reg      <= '0;
                too_long_reg <= 1'b0;
                type_reg     <= '0;
                dest_reg     <= '0;
                src_reg      <= '0;
                id_reg       <= '0;
                plen_reg     <= '0;
                rlen_reg     <= '0;
                hop_hi_reg   <= '0;
                match_reg    <= 1'b0;
                midx_reg     <= '0;
                after_reg    <= '0;
                first_reg    <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                too_long_reg <= too_long_next;
                type_reg     <= type_next;
                dest_reg     <= dest_next;
                src_reg      <= src_next;
                id_reg       <= id_next;
                plen_reg     <= plen_next;
                rlen_reg     <= rlen_next;
                hop_hi_reg   <= hop_hi_next;
                match_reg    <= match_next;
                midx_reg     <= midx_next;
                after_reg    <= after_next;
                first_reg    <= first_next;
            end
        end
    end

endmodule

FILE: rtl/srfd_decide.sv
// verdict and next hop selection from the parsed frame summary
// depends on srfd_pkg
module srfd_decide (
    input  srfd_pkg::frame_sum_t  summary,
    input  logic                  deliver_enabled,
    output srfd_pkg::decision_t   decision
);

    always_comb
    begin
        decision.verdict   = srfd_pkg::VERDICT_NO_ROUTE;
        decision.next_hop  = '0;
        decision.first_hop = '0;
        if (summary.is_short)
        begin
            decision.verdict = srfd_pkg::VERDICT_TOO_SHORT;
        end
        else if (!summary.type_ok)
        begin
            decision.verdict = srfd_pkg::VERDICT_WRONG_TYPE;
        end
        else if (!summary.len_ok)
        begin
            decision.verdict = srfd_pkg::VERDICT_LEN_ERROR;
        end
        else
        begin
            if (summary.route_nonempty)
                decision.first_hop = summary.first_hop;
            if (summary.dest_here && deliver_enabled)
            begin
                decision.verdict = srfd_pkg::VERDICT_DELIVER;
            end
            else if (summary.match_seen)
            begin
                decision.verdict  = srfd_pkg::VERDICT_FORWARD;
                // last route entry forwards straight to the destination
                decision.next_hop = summary.match_last ? summary.dest
                                                       : summary.hop_after_match;
            end
            else
            begin
                decision.verdict = srfd_pkg::VERDICT_NO_ROUTE;
            end
        end
    end

endmodule

FILE: rtl/source_route_forward_decider_core.sv
// Source-route forward decider, top level.
// Frame bytes enter on the input channel (in_valid / in_stall, frame_byte,
// frame_last), header first, one byte per transfer. Each byte lands in an
// input register; the parser updates its header fields, length count and
// route scan from that register, and on the byte flagged frame_last the
// verdict is computed and loaded into the result register.
// One result transfer per frame leaves on the output channel (out_valid /
// out_stall) with verdict, next_hop, first_hop and the header fields.
// Throughput: one byte per clock while in_stall is low. out_valid rises once
// the last byte has left the input register and its result is registered.
// When the receiver stalls, non-final bytes keep flowing; only a final byte
// waits in the input register until the result register is free, and
// in_stall is high for new bytes while it waits.
// Configuration (cfg_en, cfg_index, cfg_data): index 0 node address,
// index 1 deliver enable; write only while no frame is in flight.
// Reset clears the configuration, the parser state and both valid flags.
// depends on srfd_pkg, srfd_parser, srfd_decide
module source_route_forward_decider_core #(
    parameter int MAX_PAYLOAD = srfd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_HOPS    = srfd_pkg::MAX_HOPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_en,
    input  logic [srfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srfd_pkg::ADDR_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [srfd_pkg::BYTE_W-1:0]     frame_byte,
    input  logic                            frame_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [srfd_pkg::VERDICT_W-1:0]  verdict,
    output logic [srfd_pkg::ADDR_W-1:0]     next_hop,
    output logic [srfd_pkg::ADDR_W-1:0]     first_hop,
    output logic [srfd_pkg::ADDR_W-1:0]     origin_address,
    output logic [srfd_pkg::BYTE_W-1:0]     frame_id,
    output logic [srfd_pkg::BYTE_W-1:0]     payload_length
);

    logic [srfd_pkg::ADDR_W-1:0]    node_reg;
    logic                           deliver_reg;

    logic                           in_valid_reg, in_valid_next;
    logic [srfd_pkg::BYTE_W-1:0]    byte_reg;
    logic                           last_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [srfd_pkg::VERDICT_W-1:0] verdict_reg;
    logic [srfd_pkg::ADDR_W-1:0]    next_hop_reg;
    logic [srfd_pkg::ADDR_W-1:0]    first_hop_reg;
    logic [srfd_pkg::ADDR_W-1:0]    origin_reg;
    logic [srfd_pkg::BYTE_W-1:0]    id_reg;
    logic [srfd_pkg::BYTE_W-1:0]    plen_reg;

    logic                           advance;
    logic                           emit;
    logic                           in_take;
    srfd_pkg::frame_sum_t           summary;
    srfd_pkg::decision_t            decision;

    // a final byte needs a free result slot, other bytes always move
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign emit     = advance && last_reg;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    srfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_HOPS    (MAX_HOPS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .byte_in      (byte_reg),
        .last_in      (last_reg),
        .node_address (node_reg),
        .summary      (summary)
    );

    srfd_decide u_decide (
        .summary         (summary),
        .deliver_enabled (deliver_reg),
        .decision        (decision)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg    <= '0;
            deliver_reg <= 1'b0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                srfd_pkg::REG_NODE_ADDRESS:    node_reg    <= cfg_data;
                srfd_pkg::REG_DELIVER_ENABLED: deliver_reg <= cfg_data[0];
                default:                       node_reg    <= node_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= frame_byte;
            last_reg <= frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            verdict_reg   <= decision.verdict;
            next_hop_reg  <= decision.next_hop;
            first_hop_reg <= decision.first_hop;
            origin_reg    <= summary.source;
            id_reg        <= summary.id;
            plen_reg      <= summary.pay_len;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign next_hop       = next_hop_reg;
    assign first_hop      = first_hop_reg;
    assign origin_address = origin_reg;
    assign frame_id       = id_reg;
    assign payload_length = plen_reg;

endmodule
